// ----- design/kvtsd_pkg.sv -----
package kvtsd_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int KEY_W = 64;
   localparam int VAL_W = 64;
   localparam int REQ_DATA_W = KEY_W + VAL_W;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic step;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } sts_type;

endpackage

// ----- design/keyed_value_table_set_default_unit.sv -----
// Keyed table of 64-bit values with get and set-default requests, one result per request.
// A get returns the value of the entry whose key matches, or 0. A set-default keeps a
// nonzero stored value, fills a stored zero, or claims the lowest free entry; with the
// table full it stores nothing and returns 0. Each request walks the table memory one
// entry per cycle through its single read port, then passes a drain state and a commit
// state, where the result is registered; one request is in work at a time, and the next
// one may be accepted while the previous result still waits on the output. A result
// held back by the output stalls the next commit.
module keyed_value_table_set_default_unit #(
   parameter int TABLE_ENTRIES = kvtsd_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kvtsd_pkg::REQ_DATA_W-1:0]  req_tdata,   // lookup_key, default_value
   input  logic [0:0]                        req_tuser,   // func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kvtsd_pkg::VAL_W-1:0]       rsp_tdata    // result_value
);
   import kvtsd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   kvtsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   kvtsd_datapath #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_func  (req_tuser[0]),
      .req_key   (req_tdata[KEY_W-1:0]),
      .req_value (req_tdata[REQ_DATA_W-1:KEY_W]),
      .result    (rsp_tdata)
   );

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted during a table walk");

   // a fresh result comes a fixed walk length after its request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, TABLE_ENTRIES + 3))
      else $error("result timing does not match table walk");

   // a result leaves only by a transfer
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tvalid) |-> $past(rsp_tready))
      else $error("result dropped without transfer");

endmodule

// ----- design/kvtsd_datapath.sv -----
module kvtsd_datapath #(
   parameter int ENTRIES = kvtsd_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kvtsd_pkg::cmd_type           cmd,
   output kvtsd_pkg::sts_type           sts,
   input  logic                         req_func,
   input  logic [kvtsd_pkg::KEY_W-1:0]  req_key,
   input  logic [kvtsd_pkg::VAL_W-1:0]  req_value,
   output logic [kvtsd_pkg::VAL_W-1:0]  result
);
   import kvtsd_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [KEY_W-1:0] key_mem [ENTRIES];
   logic [VAL_W-1:0] val_mem [ENTRIES];
   logic [ENTRIES-1:0] used_ff;

   logic             func_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] dval_ff;

   logic [CNT_W-1:0] scan_cnt_ff;
   logic [IDX_W-1:0] scan_idx;

   logic [KEY_W-1:0] rd_key_ff;
   logic [VAL_W-1:0] rd_val_ff;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;

   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [VAL_W-1:0] hit_val_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;

   logic             cmp_used;
   logic             cmp_hit;

   logic             wr_val_en;
   logic             wr_key_en;
   logic [IDX_W-1:0] wr_idx;
   logic [VAL_W-1:0] result_in;
   logic [VAL_W-1:0] result_ff;

   assign scan_idx      = scan_cnt_ff[IDX_W-1:0];
   assign sts.scan_last = (scan_cnt_ff == CNT_W'(ENTRIES - 1));
   assign cmp_used      = used_ff[cmp_idx_ff];
   assign cmp_hit       = cmp_used && (rd_key_ff == key_ff);
   assign result        = result_ff;

   // request latch and scan counter
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         dval_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         if (cmd.clear) begin
            scan_cnt_ff <= '0;
         end else if (cmd.step) begin
            scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
         end
         cmp_vld_ff <= cmd.step;
      end
   end

   // table storage, one read or one write per cycle
   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_idx] <= key_ff;
      end
      if (wr_val_en) begin
         val_mem[wr_idx] <= dval_ff;
      end
      if (cmd.step) begin
         rd_key_ff <= key_mem[scan_idx];
         rd_val_ff <= val_mem[scan_idx];
      end
      cmp_idx_ff <= scan_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr_key_en) begin
         used_ff[wr_idx] <= 1'b1;
      end
   end

   // first match and first free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.clear) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmp_vld_ff) begin
         if (cmp_hit && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (!cmp_used && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_vld_ff && cmp_hit && !hit_ff) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_val_ff <= rd_val_ff;
      end
      if (cmp_vld_ff && !cmp_used && !free_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   // commit decision
   always_comb begin
      wr_val_en = 1'b0;
      wr_key_en = 1'b0;
      wr_idx    = free_idx_ff;
      result_in = '0;
      if (func_ff == FUNC_GET) begin
         if (hit_ff) begin
            result_in = hit_val_ff;
         end
      end else if (hit_ff) begin
         wr_idx = hit_idx_ff;
         if (hit_val_ff != '0) begin
            result_in = hit_val_ff;
         end else begin
            wr_val_en = cmd.commit;
            result_in = dval_ff;
         end
      end else if (free_ff) begin
         wr_val_en = cmd.commit;
         wr_key_en = cmd.commit;
         result_in = dval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         result_ff <= result_in;
      end
   end

endmodule

// ----- design/kvtsd_ctrl.sv -----
module kvtsd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output kvtsd_pkg::cmd_type cmd,
   input  kvtsd_pkg::sts_type sts
);
   import kvtsd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.clear = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
